### hw/rtl/bit_addressed_memory_core_macros.svh
// Assertion macros used by the RTL controller.
// Each one expects signals named clk and arst_n in the module that uses it.
`ifndef BIT_ADDRESSED_MEMORY_CORE_MACROS_SVH
`define BIT_ADDRESSED_MEMORY_CORE_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define BAM_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define BAM_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### hw/rtl/bam_pkg.sv
package bam_pkg;

	// field widths
	localparam int OP_W     = 3;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 32;
	localparam int FBITS_W  = 6;
	localparam int LEN_W    = 16;
	localparam int MASK_W   = 8;
	localparam int ORIGIN_W = 27;
	localparam int SIZE_W   = 11;
	localparam int LP_W     = 11;
	localparam int CFG_W    = 27;
	localparam int CFG_IDX_W = 1;

	// stream word layout
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 40;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
	localparam logic [OP_W-1:0] OP_READ_FWD = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_REV = 3'd2;
	localparam logic [OP_W-1:0] OP_SET      = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
	localparam logic [OP_W-1:0] OP_GET      = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 1'd1;

	// reset value of the size register
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// flag that get merges in when its clipped range is not empty and set never writes
	localparam logic [MASK_W-1:0] LOCAL_FLAG = 8'h80;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_wr;
		logic rd_a;
		logic rd_b;
		logic rd_c;
		logic clip_a;
		logic clip_b;
		logic walk;
		logic clr_step;
		logic finish;
	} bam_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] in_op;
		logic            cnt_zero;
		logic            clr_last;
		logic            out_free;
	} bam_stat_t;

	// bit order reversal of a 32-bit word
	function automatic logic [31:0] reverse32(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = v[31-i];
		end
		return r;
	endfunction

endpackage

### hw/rtl/bam_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module bam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/bam_ctrl.sv
`include "bit_addressed_memory_core_macros.svh"

// Sequencer: one word at a time through clear, load, read and range walk steps.
module bam_ctrl
	import bam_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  bam_stat_t stat,
	output bam_cmd_t  cmd
);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_LD   = 4'd2;
	localparam logic [3:0] ST_RA   = 4'd3;
	localparam logic [3:0] ST_RB   = 4'd4;
	localparam logic [3:0] ST_RC   = 4'd5;
	localparam logic [3:0] ST_CA   = 4'd6;
	localparam logic [3:0] ST_CB   = 4'd7;
	localparam logic [3:0] ST_WALK = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					case (stat.in_op)
						OP_LOAD:     state_d = ST_LD;
						OP_READ_FWD: state_d = ST_RA;
						OP_READ_REV: state_d = ST_RA;
						OP_SET:      state_d = ST_CA;
						OP_CLEAR:    state_d = ST_CA;
						OP_GET:      state_d = ST_CA;
						default:     state_d = ST_FIN;
					endcase
				end
			end
			ST_LD: begin
				cmd.load_wr = 1'b1;
				state_d = ST_FIN;
			end
			ST_RA: begin
				cmd.rd_a = 1'b1;
				state_d = ST_RB;
			end
			ST_RB: begin
				cmd.rd_b = 1'b1;
				state_d = ST_RC;
			end
			ST_RC: begin
				cmd.rd_c = 1'b1;
				state_d = ST_FIN;
			end
			ST_CA: begin
				cmd.clip_a = 1'b1;
				state_d = ST_CB;
			end
			ST_CB: begin
				cmd.clip_b = 1'b1;
				state_d = ST_WALK;
			end
			// the cycle that sees the count at zero retires the last entry
			ST_WALK: begin
				if (stat.cnt_zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	`BAM_ASSERT_NOW(a_no_accept_in_clear, state_q == ST_CLR, !s_tready, "word taken during clear pass")
	`BAM_ASSERT_NEXT(a_accept_leaves_idle, cmd.accept, state_q != ST_IDLE, "accept did not start work")
	`BAM_ASSERT_NOW(a_walk_has_count, cmd.walk, !stat.cnt_zero, "walk step with empty count")
	`BAM_ASSERT_NOW(a_finish_needs_room, cmd.finish, stat.out_free, "result overwrote pending word")

endmodule

### hw/rtl/bam_datapath.sv
// Datapath: config registers, word and attribute memories, clipping, output register.
module bam_datapath
	import bam_pkg::*;
#(
	parameter int MEM_WORDS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bam_cmd_t               cmd,
	output bam_stat_t              stat,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  logic [OP_W-1:0]        in_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic                   out_tvalid,
	input  logic                   out_tready,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	localparam int AW         = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int ATTR_DEPTH = MEM_WORDS * 32;
	localparam int AAW        = $clog2(ATTR_DEPTH);

	// input fields
	logic [DATA_W-1:0]  in_data;
	logic [ADDR_W-1:0]  in_addr;
	logic [FBITS_W-1:0] in_fbits;
	logic [LEN_W-1:0]   in_len;
	logic [MASK_W-1:0]  in_mask;

	assign in_data  = in_tdata[31:0];
	assign in_addr  = in_tdata[63:32];
	assign in_fbits = in_tdata[69:64];
	assign in_len   = in_tdata[85:70];
	assign in_mask  = in_tdata[93:86];

	// config registers and load pointer
	logic [ORIGIN_W-1:0] origin_q;
	logic [SIZE_W-1:0]   size_q;
	logic [LP_W-1:0]     lp_q;
	logic [SIZE_W-1:0]   eff;

	assign eff = (32'(size_q) > 32'(MEM_WORDS)) ? SIZE_W'(MEM_WORDS) : size_q;

	// latched item
	logic [OP_W-1:0]      op_q;
	logic [DATA_W-1:0]    data_q;
	logic [FBITS_W-1:0]   fbits_q;
	logic [LEN_W-1:0]     len_q;
	logic [MASK_W-1:0]    mask_q;
	logic [4:0]           sh_q;
	logic signed [27:0]   off_q;
	logic signed [27:0]   off1_q;
	logic [32:0]          diff_q;

	// read path
	logic                 inside_q, v0_q, v1_q;
	logic [31:0]          w0_q, w1, win_q;
	logic [63:0]          cat;

	// range walk
	logic signed [33:0]   n_q;
	logic [31:0]          a_q;
	logic [15:0]          ptr_q, cnt_q, paddr_s1;
	logic                 pend_s1;
	logic [MASK_W-1:0]    acc_q;
	logic [AAW-1:0]       clr_q;

	// memory ports
	logic              w_we;
	logic [AW-1:0]     w_waddr, w_raddr;
	logic [31:0]       w_rdata;
	logic              t_we;
	logic [AAW-1:0]    t_waddr, t_raddr;
	logic [MASK_W-1:0] t_wdata, t_rdata;

	logic [31:0] lp_ext, off_ext, off1_ext, ptr_ext, paddr_ext;

	// output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_q;

	assign lp_ext    = 32'(lp_q);
	assign off_ext   = 32'(off_q);
	assign off1_ext  = 32'(off1_q);
	assign ptr_ext   = 32'(ptr_q);
	assign paddr_ext = 32'(paddr_s1);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			size_q   <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN: origin_q <= cfg_data;
				REG_SIZE:   size_q   <= cfg_data[SIZE_W-1:0];
				default:    ;
			endcase
		end
	end

	// capture the item, with word offset and bit difference from the origin
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_tuser;
			data_q  <= in_data;
			fbits_q <= (in_fbits > 6'd32) ? 6'd32 : in_fbits;
			len_q   <= in_len;
			mask_q  <= in_mask;
			sh_q    <= in_addr[4:0];
			off_q   <= $signed({1'b0, in_addr[31:5]}) - $signed({1'b0, origin_q});
			diff_q  <= {1'b0, in_addr} - {1'b0, origin_q, 5'b0};
		end
	end

	// load pointer; words at or above it read as zero
	assign w_we    = cmd.load_wr && (lp_q < eff);
	assign w_waddr = lp_ext[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
		end else if (w_we) begin
			lp_q <= lp_q + 1'b1;
		end
	end

	// window read: first word, then the next one
	assign w_raddr = cmd.rd_b ? off1_ext[AW-1:0] : off_ext[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.rd_a) begin
			inside_q <= !((off_q < -28'sd1) || (off_q >= $signed({17'b0, eff})));
			v0_q     <= (off_q >= 28'sd0) && (off_q < $signed({17'b0, eff}))
				&& (off_q < $signed({17'b0, lp_q}));
			off1_q   <= off_q + 28'sd1;
		end
		if (cmd.rd_b) begin
			v1_q <= (off1_q >= 28'sd0) && (off1_q < $signed({17'b0, eff}))
				&& (off1_q < $signed({17'b0, lp_q}));
			w0_q <= v0_q ? w_rdata : 32'd0;
		end
		if (cmd.rd_c) begin
			win_q <= cat[63:32];
		end
	end

	assign w1  = v1_q ? w_rdata : 32'd0;
	assign cat = {w0_q, w1} << sh_q;

	bam_ram #(
		.WIDTH (32),
		.DEPTH (MEM_WORDS)
	) u_word_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (data_q),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// range clipping, two steps
	logic [15:0] size32, rem;
	logic        ok;

	assign size32 = {eff, 5'b0};
	assign rem    = 16'(32'(size32) - a_q);
	assign ok     = (op_q == OP_GET)
		? ((n_q > 34'sd0) && (a_q < 32'(size32)))
		: ((n_q >= 34'sd0) && (a_q <= 32'(size32)));

	always_ff @(posedge clk) begin
		if (cmd.clip_a) begin
			if (diff_q[32]) begin
				n_q <= $signed({18'b0, len_q}) + $signed({diff_q[32], diff_q});
				a_q <= '0;
			end else begin
				n_q <= $signed({18'b0, len_q});
				a_q <= diff_q[31:0];
			end
		end
	end

	// walk pointer, count and merge accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			clr_q   <= '0;
		end else begin
			pend_s1 <= cmd.walk;
			if (cmd.clip_b) begin
				ptr_q <= a_q[15:0];
				if (!ok) begin
					cnt_q <= '0;
				end else if (n_q > $signed({18'b0, rem})) begin
					cnt_q <= rem;
				end else begin
					cnt_q <= n_q[15:0];
				end
			end else if (cmd.walk) begin
				ptr_q <= ptr_q + 16'd1;
				cnt_q <= cnt_q - 16'd1;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			paddr_s1 <= ptr_q;
		end
		if (cmd.clip_b) begin
			acc_q <= ((op_q == OP_GET) && ok) ? LOCAL_FLAG : '0;
		end else if (pend_s1 && (op_q == OP_GET)) begin
			acc_q <= acc_q | t_rdata;
		end
	end

	// attribute memory: clear pass after reset, else read-modify-write
	always_comb begin
		t_we    = 1'b0;
		t_waddr = paddr_ext[AAW-1:0];
		t_wdata = t_rdata;
		if (cmd.clr_step) begin
			t_we    = 1'b1;
			t_waddr = clr_q;
			t_wdata = '0;
		end else if (pend_s1 && (op_q == OP_SET)) begin
			t_we    = 1'b1;
			t_wdata = t_rdata | (mask_q & ~LOCAL_FLAG);
		end else if (pend_s1 && (op_q == OP_CLEAR)) begin
			t_we    = 1'b1;
			t_wdata = t_rdata & ~mask_q;
		end
	end

	assign t_raddr = ptr_ext[AAW-1:0];

	bam_ram #(
		.WIDTH (MASK_W),
		.DEPTH (ATTR_DEPTH)
	) u_attr_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	// field extraction from the window
	logic [31:0]      fval;
	logic [FBITS_W-1:0] rsh;

	assign rsh = 6'd32 - fbits_q;

	always_comb begin
		fval = '0;
		if (inside_q && (fbits_q != '0)) begin
			if (op_q == OP_READ_FWD) begin
				fval = win_q >> rsh;
			end else if (op_q == OP_READ_REV) begin
				fval = reverse32(win_q & (32'hFFFF_FFFF << rsh));
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= {((op_q == OP_GET) ? acc_q : 8'd0), fval};
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_q;

	// status
	assign stat.in_op    = in_tuser;
	assign stat.cnt_zero = (cnt_q == 16'd0);
	assign stat.clr_last = (clr_q == AAW'(ATTR_DEPTH - 1));
	assign stat.out_free = !out_valid_q || out_tready;

endmodule

### hw/rtl/bit_addressed_memory_core.sv
// Channel   Direction  Contents
// s_*       in         tuser: operation; tdata: load_data, bit_address, field_bits,
//                      range_length, attr_mask
// m_*       out        tdata: field_value, merged_attr
// cfg_*     in         write enable, register index, data (origin_word, size_words)
//
// One word at a time. Load: accept, memory write, finish. Forward or reverse read:
// two reads of the single-read-port word memory, then window shift and field shift.
// Attribute set, clear and get: two clipping steps, then a walk of the attribute
// memory that takes one entry per cycle across the clipped range.
// After reset a clear pass writes zero to all MEM_WORDS*32 attribute entries,
// one per cycle; no word is taken until it ends. Config writes are taken anytime.
// A result waits in the output register while m_tready is low; the next word
// runs up to its last cycle and waits there.
module bit_addressed_memory_core
	import bam_pkg::*;
#(
	parameter int MEM_WORDS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [31:0] load_data, [63:32] bit_address, [69:64] field_bits,
	// [85:70] range_length, [93:86] attr_mask, [95:94] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [2:0] operation
	input  logic [OP_W-1:0]        s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [31:0] field_value, [39:32] merged_attr
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	bam_cmd_t  cmd;
	bam_stat_t stat;

	bam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bam_datapath #(
		.MEM_WORDS (MEM_WORDS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_tdata   (s_tdata),
		.in_tuser   (s_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_tvalid (m_tvalid),
		.out_tready (m_tready),
		.out_tdata  (m_tdata)
	);

endmodule

### dv/tb_bit_addressed_memory_core.sv
module tb_bit_addressed_memory_core;
	import bam_pkg::*;

	localparam int MEM_WORDS      = 1024;
	localparam int ATTR_DEPTH     = MEM_WORDS * 32;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 20;

	// codes the block must answer with a zero result and no other effect
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic [ORIGIN_W-1:0] ORIGIN_MAX = {ORIGIN_W{1'b1}};
	localparam logic [SIZE_W-1:0]   SIZE_MAX   = {SIZE_W{1'b1}};

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [DATA_W-1:0]  load_data;
		logic [ADDR_W-1:0]  bit_address;
		logic [FBITS_W-1:0] field_bits;
		logic [LEN_W-1:0]   range_length;
		logic [MASK_W-1:0]  attr_mask;
	} mem_access_t;

	typedef struct packed {
		logic [31:0]       field_value;
		logic [MASK_W-1:0] merged_attr;
	} access_result_t;

	typedef struct packed {
		mem_access_t    access;
		logic           typed;
		access_result_t result;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]        s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	// shadow of the block state
	bit [31:0]       mem_image [MEM_WORDS];
	bit [MASK_W-1:0] attr_image [ATTR_DEPTH];
	bit [LP_W-1:0]   load_ptr;
	bit [ORIGIN_W-1:0] cur_origin;
	bit [SIZE_W-1:0] cur_size = SIZE_RESET;

	access_result_t access_results_due[$];
	stim_row_t      directed_rows[$];
	int             errors;
	int             burst_left;
	bit             hold_request;

	bit_addressed_memory_core #(
		.MEM_WORDS(MEM_WORDS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned used_words();
		return (cur_size > MEM_WORDS) ? MEM_WORDS : cur_size;
	endfunction

	// word at a signed offset from the origin, zero outside the words in use
	function automatic bit [31:0] word_or_zero(input longint off);
		if (off < 0 || off >= longint'(used_words()))
			return '0;
		return mem_image[off];
	endfunction

	// clip an attribute range to the memory; 0 if rejected, else count may be 0
	function automatic bit clip_range(input mem_access_t acc, input bit strict,
			output int unsigned first, output int unsigned count);
		longint org32, size32, n, a;
		org32 = longint'(cur_origin) << 5;
		size32 = longint'(used_words()) << 5;
		n = longint'(acc.range_length);
		if (longint'(acc.bit_address) < org32) begin
			n -= org32 - longint'(acc.bit_address);
			a = 0;
		end else begin
			a = longint'(acc.bit_address) - org32;
		end
		if (strict ? (n <= 0 || a >= size32) : (n < 0 || a > size32))
			return 1'b0;
		if (a + n > size32)
			n = size32 - a;
		first = a;
		count = n;
		return 1'b1;
	endfunction

	// expected result of one word, updating the shadow state
	function automatic access_result_t compute_access(input mem_access_t acc);
		access_result_t r;
		int unsigned width, sh, first, count;
		longint off;
		bit [31:0] win, fld;
		bit [MASK_W-1:0] m;
		r = '0;
		width = (acc.field_bits > 32) ? 32 : acc.field_bits;
		case (acc.op)
			OP_LOAD: begin
				if (load_ptr < used_words()) begin
					mem_image[load_ptr] = acc.load_data;
					load_ptr = load_ptr + 1'b1;
				end
			end
			OP_READ_FWD, OP_READ_REV: begin
				off = longint'(acc.bit_address >> 5) - longint'(cur_origin);
				sh = acc.bit_address[4:0];
				if (!(off < -1 || off >= longint'(used_words())) && width != 0) begin
					win = word_or_zero(off) << sh;
					if (sh != 0)
						win |= word_or_zero(off + 1) >> (32 - sh);
					if (acc.op == OP_READ_FWD) begin
						r.field_value = win >> (32 - width);
					end else begin
						fld = win & (32'hFFFF_FFFF << (32 - width));
						for (int i = 0; i < 32; i++)
							r.field_value[i] = fld[31-i];
					end
				end
			end
			OP_SET, OP_CLEAR: begin
				if (clip_range(acc, 1'b0, first, count)) begin
					m = (acc.op == OP_SET) ? (acc.attr_mask & ~LOCAL_FLAG) : acc.attr_mask;
					for (int unsigned k = first; k < first + count && k < ATTR_DEPTH; k++) begin
						if (acc.op == OP_SET)
							attr_image[k] |= m;
						else
							attr_image[k] &= ~m;
					end
				end
			end
			OP_GET: begin
				if (clip_range(acc, 1'b1, first, count)) begin
					r.merged_attr = LOCAL_FLAG;
					for (int unsigned k = first; k < first + count && k < ATTR_DEPTH; k++)
						r.merged_attr |= attr_image[k];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic stim_row_t make_row(input logic [OP_W-1:0] op, input logic [31:0] data,
			input logic [31:0] addr, input logic [5:0] bits, input logic [15:0] len,
			input logic [7:0] mask, input logic typed, input logic [31:0] fval,
			input logic [7:0] attr);
		stim_row_t row;
		row.access = '{op, data, addr, bits, len, mask};
		row.typed = typed;
		row.result = '{fval, attr};
		return row;
	endfunction

	// random word, addresses mostly near the loaded data or the memory
	function automatic mem_access_t random_access();
		mem_access_t acc;
		int unsigned pick;
		longint base;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			acc.op = OP_LOAD;
		else if (pick < 40)
			acc.op = OP_READ_FWD;
		else if (pick < 58)
			acc.op = OP_READ_REV;
		else if (pick < 70)
			acc.op = OP_SET;
		else if (pick < 78)
			acc.op = OP_CLEAR;
		else if (pick < 95)
			acc.op = OP_GET;
		else
			acc.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			base = (longint'(cur_origin) << 5) - 32
				+ $urandom_range(0, (int'(load_ptr) + 2) * 32);
		else if (pick < 80)
			base = (longint'(cur_origin) << 5) - 64 + $urandom_range(0, used_words() * 32 + 128);
		else
			base = $urandom;
		acc.bit_address = base[31:0];
		acc.load_data = $urandom;
		acc.field_bits = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 32) : $urandom_range(0, 63);
		pick = $urandom_range(0, 99);
		if (pick < 60)
			acc.range_length = $urandom_range(0, 40);
		else if (pick < 90)
			acc.range_length = $urandom_range(0, 600);
		else if (pick < 98)
			acc.range_length = $urandom_range(0, 4000);
		else
			acc.range_length = $urandom_range(0, 65535);
		acc.attr_mask = $urandom;
		return acc;
	endfunction

	// sender bursts: gap when a burst runs out unless told to keep going
	task automatic pace_sender(input bit steady);
		if (!steady && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end else if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	// offer one word and record what it must return
	task automatic offer(input mem_access_t acc, input logic typed, input access_result_t typed_res);
		access_result_t want;
		s_tvalid <= 1'b1;
		s_tuser <= acc.op;
		s_tdata <= {2'b00, acc.attr_mask, acc.range_length, acc.field_bits,
			acc.bit_address, acc.load_data};
		do @(posedge clk); while (!s_tready);
		want = compute_access(acc);
		if (typed)
			want = typed_res;
		access_results_due.push_back(want);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (access_results_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// both registers, back to back
	task automatic set_config(input logic [ORIGIN_W-1:0] origin, input logic [SIZE_W-1:0] size);
		cfg_we <= 1'b1;
		cfg_index <= REG_ORIGIN;
		cfg_data <= CFG_W'(origin);
		@(posedge clk);
		cur_origin = origin;
		cfg_index <= REG_SIZE;
		cfg_data <= CFG_W'(size);
		@(posedge clk);
		cur_size = size;
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [ORIGIN_W-1:0] origin, input logic [SIZE_W-1:0] size,
			input int count, input bit with_hold);
		drain();
		set_config(origin, size);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 2) begin
				// receiver backs off while words keep coming
				hold_request = 1'b1;
				for (int j = 0; j < 30; j++) begin
					pace_sender(1'b1);
					offer(random_access(), 1'b0, '0);
				end
			end
			pace_sender(1'b0);
			offer(random_access(), 1'b0, '0);
		end
	endtask

	// receiver stall pattern
	initial begin
		int unsigned stretch, mode;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stretch = $urandom_range(1, 60);
			mode = $urandom_range(0, 3);
			repeat (stretch) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 4) == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (access_results_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = access_results_due.pop_front();
				if (m_tdata[31:0] !== want.field_value) begin
					$display("%0t: field_value mismatch, expected %h, actual %h",
						$time, want.field_value, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[39:32] !== want.merged_attr) begin
					$display("%0t: merged_attr mismatch, expected %h, actual %h",
						$time, want.merged_attr, m_tdata[39:32]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		cfg_we = 1'b0;
		cfg_index = REG_ORIGIN;
		cfg_data = '0;
		arst_n = 1'b0;
		errors = 0;
		burst_left = 0;
		hold_request = 1'b0;

		// fresh state, bottom and top of memory, cross-word fields, range clipping
		directed_rows.push_back(make_row(OP_READ_FWD, 32'h0, 32'd0, 6'd32, 16'd0, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'd0, 6'd1, 16'd8, 8'h00, 1, 32'h0, 8'h80));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'd0, 6'd1, 16'd0, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_LOAD, 32'h1234_5678, 32'd0, 6'd0, 16'd0, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_LOAD, 32'h8000_0001, 32'd0, 6'd0, 16'd0, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_LOAD, 32'hFFFF_FFFF, 32'd0, 6'd0, 16'd0, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_READ_FWD, 32'h0, 32'd0, 6'd32, 16'd0, 8'h00, 1, 32'h1234_5678, 8'h00));
		directed_rows.push_back(make_row(OP_READ_FWD, 32'h0, 32'd4, 6'd8, 16'd0, 8'h00, 1, 32'h23, 8'h00));
		directed_rows.push_back(make_row(OP_READ_REV, 32'h0, 32'd0, 6'd4, 16'd0, 8'h00, 1, 32'h8, 8'h00));
		directed_rows.push_back(make_row(OP_READ_FWD, 32'h0, 32'd28, 6'd8, 16'd0, 8'h00, 1, 32'h88, 8'h00));
		directed_rows.push_back(make_row(OP_READ_REV, 32'h0, 32'd32, 6'd32, 16'd0, 8'h00, 1, 32'h8000_0001, 8'h00));
		directed_rows.push_back(make_row(OP_READ_FWD, 32'h0, 32'd0, 6'd0, 16'd0, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_READ_FWD, 32'h0, 32'd64, 6'd63, 16'd0, 8'h00, 1, 32'hFFFF_FFFF, 8'h00));
		directed_rows.push_back(make_row(OP_READ_FWD, 32'h0, 32'hFFFF_FFE0, 6'd32, 16'd0, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_SET, 32'h0, 32'd4, 6'd1, 16'd8, 8'hFF, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'd0, 6'd1, 16'd16, 8'h00, 1, 32'h0, 8'hFF));
		directed_rows.push_back(make_row(OP_CLEAR, 32'h0, 32'd6, 6'd1, 16'd2, 8'h0F, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'd6, 6'd1, 16'd2, 8'h00, 1, 32'h0, 8'hF0));
		directed_rows.push_back(make_row(OP_SET, 32'h0, 32'd32760, 6'd1, 16'hFFFF, 8'h01, 0, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'd32767, 6'd1, 16'd1, 8'h00, 1, 32'h0, 8'h81));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'd32768, 6'd1, 16'd4, 8'h00, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_SET, 32'h0, 32'd32768, 6'd1, 16'd0, 8'h02, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_SET, 32'h0, 32'd100, 6'd1, 16'd1, 8'h80, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'd100, 6'd1, 16'd1, 8'h00, 1, 32'h0, 8'h80));
		directed_rows.push_back(make_row(OP_SPARE_6, 32'hFFFF_FFFF, 32'd0, 6'd32, 16'd8, 8'hFF, 1, 32'h0, 8'h00));
		directed_rows.push_back(make_row(OP_SPARE_7, 32'hFFFF_FFFF, 32'd0, 6'd32, 16'd8, 8'hFF, 1, 32'h0, 8'h00));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		set_config('0, SIZE_RESET);

		foreach (directed_rows[i]) begin
			pace_sender(1'b0);
			offer(directed_rows[i].access, directed_rows[i].typed, directed_rows[i].result);
		end

		// register settings: reset values, extremes, oversize, single word
		run_phase('0, SIZE_RESET, 250, 1'b1);
		run_phase(27'd100, 11'd37, 120, 1'b0);
		run_phase(ORIGIN_MAX, '0, 60, 1'b0);
		run_phase($urandom_range(0, ORIGIN_MAX), SIZE_MAX, 120, 1'b0);
		run_phase(27'd5, 11'd1, 60, 1'b0);
		run_phase($urandom, $urandom_range(1, MEM_WORDS), 140, 1'b0);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### bit_addressed_memory_core.f
+incdir+hw/rtl
hw/rtl/bam_pkg.sv
hw/rtl/bam_ram.sv
hw/rtl/bam_ctrl.sv
hw/rtl/bam_datapath.sv
hw/rtl/bit_addressed_memory_core.sv
dv/tb_bit_addressed_memory_core.sv
